>>> rtl/bblur_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the 3x3 box blur
package bblur_pkg;

    // fixed field and register widths
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int ROW_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // averaging arithmetic: sum of up to nine 8-bit values, scaled reciprocal
    localparam int SUM_W  = 12;
    localparam int RCP_SH = 16;
    localparam int RCP_W  = 17;
    localparam int PROD_W = SUM_W + RCP_W;

    // register reset values
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd768;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       pad;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_res_out;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        t_cfg_reg              index;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_wr;

    // per-item control that travels with the window column
    typedef struct packed {
        logic emit;
        logic last;
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_right;
    } t_tap_ctl;

    // ceil(2^16 / count) for the neighbor counts that can occur
    function automatic logic [RCP_W-1:0] bblur_recip(input logic [1:0] nr, input logic [1:0] nc);
        logic [3:0] cnt;
        cnt = {2'b00, nr} * {2'b00, nc};
        case (cnt)
            4'd1:    return 17'd65536;
            4'd2:    return 17'd32768;
            4'd3:    return 17'd21846;
            4'd4:    return 17'd16384;
            4'd6:    return 17'd10923;
            4'd9:    return 17'd7282;
            default: return 17'd65536;
        endcase
    endfunction

endpackage

>>> rtl/bblur_stream_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one payload of a given type
interface bblur_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> rtl/bblur_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module bblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, read port returns the old data on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bblur_line_buf.sv
`timescale 1ns / 1ps
// frame position tracking and the two line stores with write forwarding
module bblur_line_buf import bblur_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_restart,
    input  logic [FW_W-1:0] i_width,
    input  logic [FH_W-1:0] i_height,
    input  logic            i_valid,
    input  t_pix_in         i_pix,
    output logic            o_valid,
    output t_rgb            o_top,
    output t_rgb            o_mid,
    output t_rgb            o_pix,
    output t_tap_ctl        o_ctl
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int XW = ((AW > FW_W) ? AW : FW_W) + 1;
    localparam int RX = ROW_W + 1;

    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    logic             accept;
    logic [XW-1:0]    w_x;
    logic [XW-1:0]    ci;
    logic [XW-1:0]    ci_inc;
    logic [XW-1:0]    pc;
    logic [RX-1:0]    h_x;
    logic [RX-1:0]    ri;
    logic [RX-1:0]    ri_nxt;
    logic [RX-1:0]    pr;
    logic [AW-1:0]    addr0;
    t_tap_ctl         ctl0;
    t_rgb             pix0;

    logic             r_v1;
    logic [AW-1:0]    r_addr1;
    t_rgb             r_pix1;
    t_tap_ctl         r_ctl1;
    logic             r_fwd1;
    t_rgb             r_fwd_top1;
    t_rgb             r_fwd_mid1;
    t_rgb             rd_up;
    t_rgb             rd_lo;
    t_rgb             top1;
    t_rgb             mid1;

    assign accept = i_valid && i_en;

    // output position, neighborhood masks and next input position
    always_comb begin
        w_x = XW'(i_width);
        h_x = RX'(i_height);
        ri  = RX'(r_row);
        ci  = XW'(r_col);
        if (ci >= w_x) begin
            ci = w_x - 1'b1;
        end
        if (ci == '0) begin
            pc = w_x - 1'b1;
            pr = ri - RX'(2);
        end else begin
            pc = ci - 1'b1;
            pr = ri - 1'b1;
        end
        ctl0.emit      = ((ri >= RX'(2)) || ((ri == RX'(1)) && (ci != '0))) && (pr < h_x);
        ctl0.last      = (pr == h_x - 1'b1) && (pc == w_x - 1'b1);
        ctl0.row_top   = (pr != '0);
        ctl0.row_bot   = ((pr + 1'b1) < h_x);
        ctl0.col_left  = (pc != '0);
        ctl0.col_right = ((pc + 1'b1) < w_x);

        ci_inc = ci + 1'b1;
        ri_nxt = ri;
        if (ci_inc >= w_x) begin
            ci_inc = '0;
            ri_nxt = ri + 1'b1;
        end
        if (ctl0.emit && ctl0.last) begin
            n_col = '0;
            n_row = '0;
        end else if (ri_nxt > (h_x + 1'b1)) begin
            n_col = '0;
            n_row = '0;
        end else begin
            n_col = AW'(ci_inc);
            n_row = ROW_W'(ri_nxt);
        end
        addr0 = AW'(ci);
        pix0  = i_pix.pad ? t_rgb'('0)
                          : t_rgb'({i_pix.red_in, i_pix.green_in, i_pix.blue_in});
    end

    // position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // read stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= accept;
        end
    end

    // read stage payload, forward the write that lands on the same column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr1    <= addr0;
            r_pix1     <= pix0;
            r_ctl1     <= ctl0;
            r_fwd1     <= r_v1 && (r_addr1 == addr0);
            r_fwd_top1 <= mid1;
            r_fwd_mid1 <= r_pix1;
        end
    end

    // line stores: upper holds two rows back, lower one row back
    bblur_ram #(.WIDTH($bits(t_rgb)), .DEPTH(MAX_WIDTH)) u_ram_upper (
        .i_clk   (i_clk),
        .i_we    (i_en && r_v1),
        .i_waddr (r_addr1),
        .i_wdata (mid1),
        .i_re    (accept),
        .i_raddr (addr0),
        .o_rdata (rd_up)
    );

    bblur_ram #(.WIDTH($bits(t_rgb)), .DEPTH(MAX_WIDTH)) u_ram_lower (
        .i_clk   (i_clk),
        .i_we    (i_en && r_v1),
        .i_waddr (r_addr1),
        .i_wdata (r_pix1),
        .i_re    (accept),
        .i_raddr (addr0),
        .o_rdata (rd_lo)
    );

    assign top1 = r_fwd1 ? r_fwd_top1 : rd_up;
    assign mid1 = r_fwd1 ? r_fwd_mid1 : rd_lo;

    assign o_valid = r_v1;
    assign o_top   = top1;
    assign o_mid   = mid1;
    assign o_pix   = r_pix1;
    assign o_ctl   = r_ctl1;

    // input column stays inside the active width
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_col) < XW'(i_width) || i_width == '0)
        else $error("input column outside the frame width");

    // input row never passes the drain rows below the frame
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        RX'(r_row) <= RX'(i_height) + 1'b1)
        else $error("input row beyond the drain rows");

endmodule

>>> rtl/bblur_win_avg.sv
`timescale 1ns / 1ps
// 3x3 window, masked neighborhood sums and reciprocal division
module bblur_win_avg import bblur_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_rgb     i_top,
    input  t_rgb     i_mid,
    input  t_rgb     i_pix,
    input  t_tap_ctl i_ctl,
    output logic     o_valid,
    output t_res_out o_res
);

    t_rgb              r_win [3][3];
    logic              r_v2;
    t_tap_ctl          r_ctl2;
    logic              r_v3;
    logic [SUM_W-1:0]  r_sum_r;
    logic [SUM_W-1:0]  r_sum_g;
    logic [SUM_W-1:0]  r_sum_b;
    logic [RCP_W-1:0]  r_rcp3;
    logic              r_last3;
    logic              r_v4;
    logic [PROD_W-1:0] r_prod_r;
    logic [PROD_W-1:0] r_prod_g;
    logic [PROD_W-1:0] r_prod_b;
    logic              r_last4;

    logic [2:0]        row_m;
    logic [2:0]        col_m;
    logic [1:0]        nr;
    logic [1:0]        nc;
    logic [SUM_W-1:0]  sum_r;
    logic [SUM_W-1:0]  sum_g;
    logic [SUM_W-1:0]  sum_b;

    // window shift, newest column on the right
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= i_top;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_pix;
        end
    end

    // masked sums over the in-frame neighbors
    always_comb begin
        row_m = {r_ctl2.row_bot, 1'b1, r_ctl2.row_top};
        col_m = {r_ctl2.col_right, 1'b1, r_ctl2.col_left};
        nr    = 2'd1 + {1'b0, r_ctl2.row_top} + {1'b0, r_ctl2.row_bot};
        nc    = 2'd1 + {1'b0, r_ctl2.col_left} + {1'b0, r_ctl2.col_right};
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (row_m[r] && col_m[c]) begin
                    sum_r = sum_r + SUM_W'(r_win[r][c].red);
                    sum_g = sum_g + SUM_W'(r_win[r][c].green);
                    sum_b = sum_b + SUM_W'(r_win[r][c].blue);
                end
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_valid && i_ctl.emit;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // sum and multiply stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl2   <= i_ctl;
            r_sum_r  <= sum_r;
            r_sum_g  <= sum_g;
            r_sum_b  <= sum_b;
            r_rcp3   <= bblur_recip(nr, nc);
            r_last3  <= r_ctl2.last;
            r_prod_r <= PROD_W'(r_sum_r) * PROD_W'(r_rcp3);
            r_prod_g <= PROD_W'(r_sum_g) * PROD_W'(r_rcp3);
            r_prod_b <= PROD_W'(r_sum_b) * PROD_W'(r_rcp3);
            r_last4  <= r_last3;
        end
    end

    assign o_valid         = r_v4;
    assign o_res.red_out   = r_prod_r[RCP_SH +: 8];
    assign o_res.green_out = r_prod_g[RCP_SH +: 8];
    assign o_res.blue_out  = r_prod_b[RCP_SH +: 8];
    assign o_res.frame_end = r_last4;

    // a mean never exceeds one channel value
    a_mean_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_prod_r[PROD_W-1:RCP_SH+8] == '0) && (r_prod_g[PROD_W-1:RCP_SH+8] == '0)
                 && (r_prod_b[PROD_W-1:RCP_SH+8] == '0))
        else $error("neighborhood mean overflows eight bits");

endmodule

>>> rtl/box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// top level of the streaming 3x3 rgb box blur
//
// i_pix takes frame pixels in raster order, one transaction a clock while
// ready is high. o_res gives the truncated 3x3 mean of each frame pixel
// over the neighbors that lie inside the frame; frame_end marks the frame's
// last pixel. A pixel's result is due once the pixel one row and one column
// further on has been accepted; after the frame, send frame_width+1 pad
// transactions. i_cfg writes frame_width (index 0) and frame_height (index
// 1); the user must write them only while the block is idle, which the
// block itself does not enforce; a write to either restarts the frame
// position. Throughput is one pixel a clock while the skid register is
// empty: each column of the line stores is read and rewritten once per
// pixel, with the write of the previous pixel forwarded when both touch
// the same column. A result is registered through ram read, window, sums,
// multiply and output. Reset: position zero, width 1024, height 768; the
// line stores are not cleared, entries never written are only read outside
// the frame. A stalled o_res holds its transaction; one more result goes to
// a skid register, after which i_pix.ready falls until the output drains.
module box_blur_3x3_rgb import bblur_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bblur_stream_if.sink   i_pix,
    bblur_stream_if.source o_res,
    bblur_stream_if.sink   i_cfg
);

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic [FW_W-1:0] width_eff;
    logic [FH_W-1:0] height_eff;
    logic            cfg_acc;
    logic            restart;
    logic            en;

    logic            lb_valid;
    t_rgb            lb_top;
    t_rgb            lb_mid;
    t_rgb            lb_pix;
    t_tap_ctl        lb_ctl;
    logic            avg_valid;
    t_res_out        avg_res;

    logic            r_out_valid;
    t_res_out        r_out;
    logic            r_skid_valid;
    t_res_out        r_skid;
    logic            n_out_valid;
    t_res_out        n_out;
    logic            n_skid_valid;
    t_res_out        n_skid;
    logic            res_take;

    // configuration registers
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign restart     = cfg_acc && ((i_cfg.data.index == CFG_FRAME_WIDTH) ||
                                     (i_cfg.data.index == CFG_FRAME_HEIGHT));
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (cfg_acc) begin
            case (i_cfg.data.index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data.wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data.wdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the frame size into the supported range
    always_comb begin
        if (r_frame_width == '0) begin
            width_eff = FW_W'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            width_eff = FW_W'(MAX_WIDTH);
        end else begin
            width_eff = r_frame_width;
        end
        height_eff = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
    end

    // the whole pipeline advances unless the skid register is occupied
    assign en          = !r_skid_valid;
    assign i_pix.ready = en;

    bblur_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_restart (restart),
        .i_width   (width_eff),
        .i_height  (height_eff),
        .i_valid   (i_pix.valid),
        .i_pix     (i_pix.data),
        .o_valid   (lb_valid),
        .o_top     (lb_top),
        .o_mid     (lb_mid),
        .o_pix     (lb_pix),
        .o_ctl     (lb_ctl)
    );

    bblur_win_avg u_win_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (lb_valid),
        .i_top   (lb_top),
        .i_mid   (lb_mid),
        .i_pix   (lb_pix),
        .i_ctl   (lb_ctl),
        .o_valid (avg_valid),
        .o_res   (avg_res)
    );

    // output register with one skid entry
    assign res_take = r_out_valid && o_res.ready;

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (res_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (avg_valid) begin
            if (!r_out_valid || res_take) begin
                n_out       = avg_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = avg_res;
                n_skid_valid = 1'b1;
            end
        end else if (res_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // the skid entry is always behind a held output transaction
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without an output transaction");

    // the skid only fills while the receiver stalls
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_res.ready))
        else $error("skid filled without an output stall");

endmodule
